### hw/rtl/fixed_width_number_formatter_macros.svh
// Assertion macros for the checker file.
`ifndef FIXED_WIDTH_NUMBER_FORMATTER_MACROS_SVH
`define FIXED_WIDTH_NUMBER_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FWNF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FWNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/fwnf_pkg.sv
package fwnf_pkg;

	// field widths
	localparam int VALUE_W = 31;
	localparam int CNT_W   = 4;
	localparam int MODE_W  = 2;
	localparam int KIND_W  = 2;
	localparam int DIGIT_W = 4;

	// digit limits
	localparam int MAX_DIGITS = 10;
	localparam int HEX_DIGITS = 8;

	// binary to BCD conversion: one shift step per value bit, padded to 32
	localparam int BCD_W           = MAX_DIGITS * DIGIT_W;
	localparam int BIN_W           = 32;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DD_STAGES       = BIN_W / STEPS_PER_STAGE;

	// alignment codes; code 3 behaves as left align
	localparam logic [MODE_W-1:0] ALIGN_LEFT  = 2'd0;
	localparam logic [MODE_W-1:0] ALIGN_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] ALIGN_ZERO  = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_DIGIT    = 2'd0,
		KIND_SPACE    = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	// one number in flight
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [BIN_W-1:0]   bin;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   count;
		logic [MODE_W-1:0]  mode;
		logic               hex;
	} item_t;

	// one double-dabble step: add 3 to every digit >= 5, then shift left
	function automatic item_t dd_step(input item_t it);
		item_t            r;
		logic [BCD_W-1:0] adj;
		r   = it;
		adj = it.bcd;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (adj[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = adj[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end
		end
		{r.bcd, r.bin} = {adj[BCD_W-2:0], it.bin, 1'b0};
		return r;
	endfunction

endpackage

### hw/rtl/fwnf_bcd_pipe.sv
module fwnf_bcd_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fwnf_pkg::item_t in_item,
	output logic            in_ready,
	output logic            out_valid,
	output fwnf_pkg::item_t out_item,
	input  logic            out_ready
);
	import fwnf_pkg::*;

	logic [DD_STAGES-1:0] vld_s;
	item_t                item_s [DD_STAGES];
	logic [DD_STAGES:0]   rdy;

	assign rdy[DD_STAGES] = out_ready;
	assign in_ready       = rdy[0];
	assign out_valid      = vld_s[DD_STAGES-1];
	assign out_item       = item_s[DD_STAGES-1];

	for (genvar k = 0; k < DD_STAGES; k++) begin : g_stage
		item_t src;
		item_t nxt;
		logic  src_v;

		if (k == 0) begin : g_first
			assign src   = in_item;
			assign src_v = in_valid;
		end else begin : g_rest
			assign src   = item_s[k-1];
			assign src_v = vld_s[k-1];
		end

		// a stage loads when empty or when its contents move on
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		// a few shift steps per stage
		always_comb begin
			nxt = src;
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				nxt = dd_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				item_s[k] <= nxt;
			end
		end
	end

endmodule

### hw/rtl/fwnf_serializer.sv
module fwnf_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  fwnf_pkg::item_t               in_item,
	output logic                          take,
	output logic                          strobe,
	output logic [fwnf_pkg::KIND_W-1:0]   symbol_kind,
	output logic [fwnf_pkg::DIGIT_W-1:0]  digit_value,
	output logic                          last_symbol
);
	import fwnf_pkg::*;

	// held number
	logic                 act_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 first_q;
	logic                 wr_q;
	logic                 spaces_q;
	logic                 ovf_q;
	logic                 lead_q;
	logic [DIGIT_W-1:0]   digs_q [MAX_DIGITS];

	// result register
	logic                 strobe_q;
	kind_t                kind_q;
	logic [DIGIT_W-1:0]   dval_q;
	logic                 last_q;

	// load-side decode
	logic [BCD_W-1:0]     hex_pad;
	logic [DIGIT_W-1:0]   ld_digs [MAX_DIGITS];
	logic                 ld_ovf;
	logic                 ld_lead;

	// per-position decode
	logic [DIGIT_W-1:0]   cur;
	logic                 qnz;
	logic                 zero_pos;
	logic                 emit;
	logic                 ovf_here;
	logic                 strobe_d;
	kind_t                kind_d;
	logic [DIGIT_W-1:0]   dval_d;

	assign take = !act_q || (pos_q == '0);

	// digits of the incoming number, and whether anything sits above the field
	assign hex_pad = {{(BCD_W-VALUE_W){1'b0}}, in_item.value};

	always_comb begin
		ld_ovf  = 1'b0;
		ld_lead = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			ld_digs[i] = in_item.hex ? hex_pad[i*DIGIT_W +: DIGIT_W]
			                         : in_item.bcd[i*DIGIT_W +: DIGIT_W];
			if (ld_digs[i] != '0) begin
				if (CNT_W'(i) >= in_item.count) begin
					ld_ovf = 1'b1;
				end
				if (CNT_W'(i + 1) >= in_item.count) begin
					ld_lead = 1'b1;
				end
			end
		end
	end

	// current position: leading one uses the whole quotient
	always_comb begin
		cur      = digs_q[pos_q];
		qnz      = first_q ? lead_q : (cur != '0);
		zero_pos = (pos_q == '0);
		emit     = wr_q || qnz || zero_pos;
		ovf_here = first_q && ovf_q;
		strobe_d = act_q && (emit || spaces_q);
		if (!emit) begin
			kind_d = KIND_SPACE;
			dval_d = '0;
		end else if (ovf_here) begin
			kind_d = KIND_OVERFLOW;
			dval_d = '0;
		end else begin
			kind_d = KIND_DIGIT;
			dval_d = cur;
		end
	end

	// position sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (take) begin
			act_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			pos_q    <= in_item.count - 1'b1;
			first_q  <= 1'b1;
			wr_q     <= (in_item.mode == ALIGN_ZERO);
			spaces_q <= (in_item.mode == ALIGN_RIGHT);
			ovf_q    <= ld_ovf;
			lead_q   <= ld_lead;
			digs_q   <= ld_digs;
		end else if (!take) begin
			pos_q   <= pos_q - 1'b1;
			first_q <= 1'b0;
			wr_q    <= wr_q || qnz;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		dval_q <= dval_d;
		last_q <= zero_pos;
	end

	assign strobe      = strobe_q;
	assign symbol_kind = kind_q;
	assign digit_value = dval_q;
	assign last_symbol = last_q;

endmodule

### hw/rtl/fixed_width_number_formatter.sv
// Fixed-width number formatter.
// Input: a number is taken at a clock edge with start high and busy low
// (number_value, digit_count, align_mode). Output: one beat per emitted
// position, most significant first, on strobe with symbol_kind, digit_value
// and last_symbol; the last beat of a number has last_symbol set.
// Config: radix_hex is written when radix_hex_we is high; write it only while
// no number is in flight.
// Path: a number passes the 8 BCD conversion stages, then the serializer's
// held-number register and its output beat register.
// Throughput: one position per cycle, so a number holds the serializer for as
// many positions as its clamped digit count, 1 to 10 (at most 8 in hex); left-aligned
// leading zeros take their position without a beat. The serializer sets the sustained rate; the
// conversion stages hold up to 8 further numbers and busy rises when the
// first stage is full and cannot advance.
// Reset: arst_n clears all valid bits and sets radix_hex to decimal.
// The receiver cannot stall; each beat is shown for exactly one cycle.
module fixed_width_number_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fwnf_pkg::VALUE_W-1:0]  number_value,
	input  logic [fwnf_pkg::CNT_W-1:0]    digit_count,
	input  logic [fwnf_pkg::MODE_W-1:0]   align_mode,
	input  logic                          radix_hex_we,
	input  logic                          radix_hex,
	output logic                          strobe,
	output logic [fwnf_pkg::KIND_W-1:0]   symbol_kind,
	output logic [fwnf_pkg::DIGIT_W-1:0]  digit_value,
	output logic                          last_symbol
);
	import fwnf_pkg::*;

	logic             radix_hex_q;
	logic [CNT_W-1:0] cnt;
	item_t            in_item;
	logic             in_ready;
	logic             pipe_valid;
	item_t            pipe_item;
	logic             ser_take;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_hex_q <= 1'b0;
		end else if (radix_hex_we) begin
			radix_hex_q <= radix_hex;
		end
	end

	// clamp the digit count
	always_comb begin
		cnt = digit_count;
		if (cnt == '0) begin
			cnt = CNT_W'(1);
		end
		if (cnt > CNT_W'(MAX_DIGITS)) begin
			cnt = CNT_W'(MAX_DIGITS);
		end
		if (radix_hex_q && (cnt > CNT_W'(HEX_DIGITS))) begin
			cnt = CNT_W'(HEX_DIGITS);
		end
	end

	always_comb begin
		in_item       = '0;
		in_item.bin   = {{(BIN_W-VALUE_W){1'b0}}, number_value};
		in_item.value = number_value;
		in_item.count = cnt;
		in_item.mode  = align_mode;
		in_item.hex   = radix_hex_q;
	end

	assign busy = !in_ready;

	fwnf_bcd_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_item   (in_item),
		.in_ready  (in_ready),
		.out_valid (pipe_valid),
		.out_item  (pipe_item),
		.out_ready (ser_take)
	);

	fwnf_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pipe_valid),
		.in_item     (pipe_item),
		.take        (ser_take),
		.strobe      (strobe),
		.symbol_kind (symbol_kind),
		.digit_value (digit_value),
		.last_symbol (last_symbol)
	);

endmodule

### hw/rtl/fwnf_checker.sv
`include "fixed_width_number_formatter_macros.svh"

module fwnf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          strobe,
	input  logic [fwnf_pkg::KIND_W-1:0]   symbol_kind,
	input  logic [fwnf_pkg::DIGIT_W-1:0]  digit_value,
	input  logic                          last_symbol
);
	import fwnf_pkg::*;

	// a space never ends a number and carries no digit
	`FWNF_ASSERT_NOW(a_space_clean, strobe && (symbol_kind == KIND_SPACE), (digit_value == '0) && !last_symbol, "space beat with digit or last flag")

	// an overflow mark carries no digit
	`FWNF_ASSERT_NOW(a_ovf_clean, strobe && (symbol_kind == KIND_OVERFLOW), digit_value == '0, "overflow beat with nonzero digit")

	// no unused kind code on a beat
	`FWNF_ASSERT_NOW(a_kind_code, strobe, (symbol_kind == KIND_DIGIT) || (symbol_kind == KIND_SPACE) || (symbol_kind == KIND_OVERFLOW), "unused symbol kind")

	// once a number has shown a beat, its beats run back to back to the last
	`FWNF_ASSERT_NEXT(a_no_gap, strobe && !last_symbol, strobe, "gap inside a number")

endmodule

bind fixed_width_number_formatter fwnf_checker u_fwnf_checker (.*);

### sim/fixed_width_number_formatter_tb.sv
module fixed_width_number_formatter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fwnf_pkg::*;

	// code 3 has no name in the package; it must act as left align
	localparam logic [MODE_W-1:0] ALIGN_SPARE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 24;

	typedef struct {
		kind_t               kind;
		logic [DIGIT_W-1:0]  digit;
		logic                last;
	} symbol_t;

	// expected symbol stream, built per accepted number, drained per beat
	class symbol_tracker;
		bit      hex;
		int      errors;
		symbol_t symbols_due[$];

		function void predict_symbols(logic [VALUE_W-1:0] value, logic [CNT_W-1:0] count,
				logic [MODE_W-1:0] mode);
			int unsigned width, rest, place, quot, top;
			bit          lead_done, pad;
			symbol_t     s;
			width = 32'(count);
			if (width < 1) width = 1;
			if (width > MAX_DIGITS) width = MAX_DIGITS;
			if (hex && width > HEX_DIGITS) width = HEX_DIGITS;
			top       = hex ? 15 : 9;
			rest      = 32'(value);
			lead_done = (mode == ALIGN_ZERO);
			pad       = (mode == ALIGN_RIGHT);
			for (int i = int'(width) - 1; i >= 0; i--) begin
				if (hex) begin
					place = 32'd1 << (4 * i);
				end else begin
					place = 1;
					for (int k = 0; k < i; k++) place = place * 10;
				end
				quot = rest / place;
				rest = rest % place;
				s.last = 1'b0;
				// units position always prints; leading zeros depend on mode
				if (lead_done || quot != 0 || i == 0) begin
					lead_done = 1'b1;
					if (quot > top) begin
						s.kind  = KIND_OVERFLOW;
						s.digit = '0;
					end else begin
						s.kind  = KIND_DIGIT;
						s.digit = quot[DIGIT_W-1:0];
					end
					symbols_due.push_back(s);
				end else if (pad) begin
					s.kind  = KIND_SPACE;
					s.digit = '0;
					symbols_due.push_back(s);
				end
			end
			symbols_due[symbols_due.size() - 1].last = 1'b1;
		endfunction

		function void check_symbol(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit,
				logic last);
			symbol_t want;
			if (symbols_due.size() == 0) begin
				$error("unexpected beat: kind %0d digit %0d last %0d", kind, digit, last);
				errors++;
				return;
			end
			want = symbols_due.pop_front();
			if (kind !== want.kind) begin
				$error("symbol_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (digit !== want.digit) begin
				$error("digit_value: expected %0d, got %0d", want.digit, digit);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_symbol: expected %0d, got %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [VALUE_W-1:0]  number_value = '0;
	logic [CNT_W-1:0]    digit_count = '0;
	logic [MODE_W-1:0]   align_mode = '0;
	logic                radix_hex_we = 1'b0;
	logic                radix_hex = 1'b0;
	logic                strobe;
	logic [KIND_W-1:0]   symbol_kind;
	logic [DIGIT_W-1:0]  digit_value;
	logic                last_symbol;

	symbol_tracker tracker = new;
	int            idle_pct;
	int            idle_pct_set[3] = '{23, 58, 0};
	int            stall_cycles;

	fixed_width_number_formatter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.number_value (number_value),
		.digit_count  (digit_count),
		.align_mode   (align_mode),
		.radix_hex_we (radix_hex_we),
		.radix_hex    (radix_hex),
		.strobe       (strobe),
		.symbol_kind  (symbol_kind),
		.digit_value  (digit_value),
		.last_symbol  (last_symbol)
	);

	always #6 clk = ~clk;

	// output beats are taken at the edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && strobe) tracker.check_symbol(symbol_kind, digit_value, last_symbol);
	end

	// watchdog: cycles without any accepted beat on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one number; start stays high into the next call unless a gap is drawn
	task automatic send_number(logic [VALUE_W-1:0] value, logic [CNT_W-1:0] count,
			logic [MODE_W-1:0] mode);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		number_value <= value;
		digit_count  <= count;
		align_mode   <= mode;
		do @(posedge clk); while (busy);
		tracker.predict_symbols(value, count, mode);
	endtask

	// register write once every pending symbol has come out
	task automatic write_radix(bit hex);
		start <= 1'b0;
		while (tracker.symbols_due.size() != 0) @(posedge clk);
		radix_hex_we <= 1'b1;
		radix_hex    <= hex;
		@(posedge clk);
		radix_hex_we <= 1'b0;
		tracker.hex = hex;
	endtask

	task automatic send_random_number();
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   count;
		// spread magnitudes so every leading-zero depth shows up
		value = VALUE_W'($urandom >> $urandom_range(31, 1));
		if ($urandom_range(9) < 8) count = CNT_W'($urandom_range(10, 1));
		else count = CNT_W'($urandom_range(15));
		send_number(value, count, MODE_W'($urandom_range(3)));
	endtask

	initial begin
		idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed decimal
		write_radix(1'b0);
		send_number(0, 1, ALIGN_LEFT);
		send_number(0, 10, ALIGN_LEFT);
		send_number(0, 10, ALIGN_RIGHT);
		send_number(0, 10, ALIGN_ZERO);
		send_number(31'h7FFF_FFFF, 10, ALIGN_ZERO);
		send_number(31'h7FFF_FFFF, 10, ALIGN_LEFT);
		send_number(12345, 2, ALIGN_RIGHT);
		send_number(999, 3, ALIGN_LEFT);
		send_number(1000, 3, ALIGN_ZERO);
		send_number(5, 0, ALIGN_RIGHT);
		send_number(123456, 15, ALIGN_RIGHT);
		send_number(4096, 4, ALIGN_SPARE);
		send_number(1000000000, 10, ALIGN_LEFT);
		send_number(7, 10, ALIGN_RIGHT);

		// directed hex: width clamp to 8 and leading overflow
		write_radix(1'b1);
		send_number(31'h7FFF_FFFF, 8, ALIGN_ZERO);
		send_number(31'h7FFF_FFFF, 12, ALIGN_LEFT);
		send_number(31'h00AB_CDEF, 6, ALIGN_LEFT);
		send_number(31'h0000_00FF, 1, ALIGN_ZERO);
		send_number(0, 8, ALIGN_RIGHT);
		send_number(31'h0000_0010, 9, ALIGN_RIGHT);
		send_number(31'h0000_1234, 3, ALIGN_SPARE);

		// random: three idle profiles, each in both radixes
		foreach (idle_pct_set[p]) begin
			idle_pct = idle_pct_set[p];
			for (int r = 0; r < 2; r++) begin
				write_radix(r[0] ^ p[0]);
				repeat (75) send_random_number();
			end
		end
		start <= 1'b0;

		while (tracker.symbols_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
